>>> hw/rtl/qaft_pkg.sv
// ----------------------------------------------------------------------------
// qaft_pkg
// Shared types and constants for the quote-aware field tokenizer.
// ----------------------------------------------------------------------------
package qaft_pkg;

    localparam int DELIM_REGS      = 4;
    localparam int MAX_DELIM_DEF   = 4;
    localparam int CNT_W           = 3;
    localparam int BYTE_W          = 8;
    localparam int ERR_W           = 2;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'd34;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'd39;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'd9;

    typedef enum logic [2:0] {
        REG_MERGE_MODE  = 3'd0,
        REG_CHUNK_MODE  = 3'd1,
        REG_CHUNK_LEN   = 3'd2,
        REG_DELIM_COUNT = 3'd3,
        REG_DELIM_A     = 3'd4,
        REG_DELIM_B     = 3'd5,
        REG_DELIM_C     = 3'd6,
        REG_DELIM_D     = 3'd7
    } reg_idx_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_OPEN_DQ = 2'd1,
        ERR_OPEN_SQ = 2'd2,
        ERR_JUNK    = 2'd3
    } err_t;

    typedef enum logic [4:0] {
        PH_BETWEEN = 5'b00001,
        PH_PLAIN   = 5'b00010,
        PH_DQ      = 5'b00100,
        PH_SQ      = 5'b01000,
        PH_AFTERQ  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic                                merge_mode;
        logic                                chunk_mode;
        logic [BYTE_W-1:0]                   chunk_length;
        logic [CNT_W-1:0]                    delimiter_count;
        logic [DELIM_REGS-1:0][BYTE_W-1:0]   delim;
    } cfg_t;

endpackage

>>> hw/rtl/quote_aware_field_tokenizer.sv
// ----------------------------------------------------------------------------
// quote_aware_field_tokenizer
// Splits a character stream into tokens by delimiters, quotes or chunks.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   s_       | in  | s_valid / s_ready   | char_byte, final_char
//   m_       | out | m_valid / m_ready   | token_byte, byte_present, token_done,
//            |     |                     | line_done, error_code
//   apb      | in  | psel/penable/pready | 8 registers at 4*i
//
// One character per cycle; a result appears in the cycle after its character.
// The single output register sets the rate: s_ready is high while it is
// empty or being drained in the same cycle. Some characters yield no beat.
// Reset (aresetn low, synchronous) loads register defaults and clears scan
// state; there is no clearing pass.
// ----------------------------------------------------------------------------
module quote_aware_field_tokenizer #(
    parameter int MAX_DELIMITERS = qaft_pkg::MAX_DELIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qaft_pkg::PADDR_W-1:0]  paddr,
    input  logic [qaft_pkg::PDATA_W-1:0]  pwdata,
    output logic [qaft_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [qaft_pkg::BYTE_W-1:0]   s_char_byte,
    input  logic                          s_final_char,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qaft_pkg::BYTE_W-1:0]   m_token_byte,
    output logic                          m_byte_present,
    output logic                          m_token_done,
    output logic                          m_line_done,
    output logic [qaft_pkg::ERR_W-1:0]    m_error_code
);
    import qaft_pkg::*;

    cfg_t cfg;

    qaft_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qaft_scan_core #(
        .MAX_DELIMITERS (MAX_DELIMITERS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_final_char   (s_final_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_byte   (m_token_byte),
        .m_byte_present (m_byte_present),
        .m_token_done   (m_token_done),
        .m_line_done    (m_line_done),
        .m_error_code   (m_error_code)
    );

endmodule

>>> hw/rtl/qaft_cfg_regs.sv
// ----------------------------------------------------------------------------
// qaft_cfg_regs
// APB-style configuration registers: modes, chunk length, delimiter bytes.
// ----------------------------------------------------------------------------
module qaft_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qaft_pkg::PADDR_W-1:0]  paddr,
    input  logic [qaft_pkg::PDATA_W-1:0]  pwdata,
    output logic [qaft_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output qaft_pkg::cfg_t                cfg
);
    import qaft_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.merge_mode      <= 1'b1;
            cfg_reg.chunk_mode      <= 1'b0;
            cfg_reg.chunk_length    <= 8'd1;
            cfg_reg.delimiter_count <= 3'd2;
            cfg_reg.delim[0]        <= CH_SPACE;
            cfg_reg.delim[1]        <= CH_TAB;
            cfg_reg.delim[2]        <= '0;
            cfg_reg.delim[3]        <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_MERGE_MODE:  cfg_reg.merge_mode      <= pwdata[0];
                REG_CHUNK_MODE:  cfg_reg.chunk_mode      <= pwdata[0];
                REG_CHUNK_LEN:   cfg_reg.chunk_length    <= pwdata[BYTE_W-1:0];
                REG_DELIM_COUNT: cfg_reg.delimiter_count <= pwdata[CNT_W-1:0];
                REG_DELIM_A:     cfg_reg.delim[0]        <= pwdata[BYTE_W-1:0];
                REG_DELIM_B:     cfg_reg.delim[1]        <= pwdata[BYTE_W-1:0];
                REG_DELIM_C:     cfg_reg.delim[2]        <= pwdata[BYTE_W-1:0];
                REG_DELIM_D:     cfg_reg.delim[3]        <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_MERGE_MODE:  prdata[0]              = cfg_reg.merge_mode;
            REG_CHUNK_MODE:  prdata[0]              = cfg_reg.chunk_mode;
            REG_CHUNK_LEN:   prdata[BYTE_W-1:0]     = cfg_reg.chunk_length;
            REG_DELIM_COUNT: prdata[CNT_W-1:0]      = cfg_reg.delimiter_count;
            REG_DELIM_A:     prdata[BYTE_W-1:0]     = cfg_reg.delim[0];
            REG_DELIM_B:     prdata[BYTE_W-1:0]     = cfg_reg.delim[1];
            REG_DELIM_C:     prdata[BYTE_W-1:0]     = cfg_reg.delim[2];
            REG_DELIM_D:     prdata[BYTE_W-1:0]     = cfg_reg.delim[3];
            default:         prdata                 = '0;
        endcase
    end

endmodule

>>> hw/rtl/qaft_scan_core.sv
// ----------------------------------------------------------------------------
// qaft_scan_core
// Per-character scanner state and the registered result beat.
// ----------------------------------------------------------------------------
module qaft_scan_core #(
    parameter int MAX_DELIMITERS = qaft_pkg::MAX_DELIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qaft_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [qaft_pkg::BYTE_W-1:0]   s_char_byte,
    input  logic                          s_final_char,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qaft_pkg::BYTE_W-1:0]   m_token_byte,
    output logic                          m_byte_present,
    output logic                          m_token_done,
    output logic                          m_line_done,
    output logic [qaft_pkg::ERR_W-1:0]    m_error_code
);
    import qaft_pkg::*;

    localparam int DelimLimit = (MAX_DELIMITERS < DELIM_REGS) ? MAX_DELIMITERS : DELIM_REGS;

    phase_t            phase_reg, phase_next;
    logic              has_bytes_reg, has_bytes_next;
    logic [BYTE_W-1:0] fill_reg, fill_next;
    logic              failed_reg, failed_next;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] tok_byte_reg;
    logic              present_reg, tdone_reg, ldone_reg;
    err_t              err_reg;

    logic              emit;
    logic [BYTE_W-1:0] o_byte;
    logic              o_present, o_tdone;
    err_t              o_err;

    logic              accept;
    logic              is_delim;
    logic [BYTE_W-1:0] fill_inc;
    logic              chunk_done;
    logic              q_match;
    logic              tok_close;
    logic [BYTE_W-1:0] c;
    logic              f;

    assign c       = s_char_byte;
    assign f       = s_final_char;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_delim = 1'b0;
        for (int i = 0; i < DELIM_REGS; i++) begin
            if (i < DelimLimit && CNT_W'(i) < cfg.delimiter_count && cfg.delim[i] == c) begin
                is_delim = 1'b1;
            end
        end
    end

    assign fill_inc   = fill_reg + 8'd1;
    assign chunk_done = (fill_inc == cfg.chunk_length) || f;
    assign q_match    = (phase_reg == PH_DQ) ? (c == CH_DQUOTE) : (c == CH_SQUOTE);
    assign tok_close  = has_bytes_reg || !cfg.merge_mode;

    always_comb begin
        phase_next     = phase_reg;
        has_bytes_next = has_bytes_reg;
        fill_next      = fill_reg;
        failed_next    = failed_reg;
        emit           = 1'b0;
        o_byte         = '0;
        o_present      = 1'b0;
        o_tdone        = 1'b0;
        o_err          = ERR_NONE;

        if (failed_reg) begin
            emit  = f;
            o_err = ERR_JUNK;
        end else if (cfg.chunk_mode) begin
            fill_next = chunk_done ? '0 : fill_inc;
            emit      = 1'b1;
            o_byte    = c;
            o_present = 1'b1;
            o_tdone   = chunk_done;
        end else begin
            case (phase_reg)
                PH_PLAIN: begin
                    emit = 1'b1;
                    if (is_delim) begin
                        phase_next = PH_BETWEEN;
                        o_tdone    = 1'b1;
                    end else begin
                        o_byte    = c;
                        o_present = 1'b1;
                        o_tdone   = f;
                    end
                end
                PH_DQ, PH_SQ: begin
                    if (q_match) begin
                        phase_next = PH_AFTERQ;
                        if (f) begin
                            emit    = 1'b1;
                            o_tdone = tok_close;
                        end
                    end else if (f) begin
                        emit  = 1'b1;
                        o_err = (phase_reg == PH_DQ) ? ERR_OPEN_DQ : ERR_OPEN_SQ;
                    end else begin
                        has_bytes_next = 1'b1;
                        emit           = 1'b1;
                        o_byte         = c;
                        o_present      = 1'b1;
                    end
                end
                PH_AFTERQ: begin
                    if (is_delim) begin
                        has_bytes_next = 1'b0;
                        phase_next     = PH_BETWEEN;
                        emit           = tok_close || f;
                        o_tdone        = tok_close;
                    end else if (f) begin
                        emit  = 1'b1;
                        o_err = ERR_JUNK;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    if (cfg.merge_mode && is_delim) begin
                        emit = f;
                    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        phase_next     = (c == CH_DQUOTE) ? PH_DQ : PH_SQ;
                        has_bytes_next = 1'b0;
                        emit           = f;
                        o_err          = f ? ((c == CH_DQUOTE) ? ERR_OPEN_DQ : ERR_OPEN_SQ)
                                           : ERR_NONE;
                    end else if (is_delim) begin
                        phase_next = PH_BETWEEN;
                        emit       = 1'b1;
                        o_tdone    = 1'b1;
                    end else begin
                        phase_next = PH_PLAIN;
                        emit       = 1'b1;
                        o_byte     = c;
                        o_present  = 1'b1;
                        o_tdone    = f;
                    end
                end
            endcase
        end

        // line end: return all scan state to reset
        if (f) begin
            phase_next     = PH_BETWEEN;
            has_bytes_next = 1'b0;
            fill_next      = '0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_BETWEEN;
            has_bytes_reg <= 1'b0;
            fill_reg      <= '0;
            failed_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                has_bytes_reg <= has_bytes_next;
                fill_reg      <= fill_next;
                failed_reg    <= failed_next;
            end
            if (s_ready) begin
                m_valid_reg <= accept && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            tok_byte_reg <= o_byte;
            present_reg  <= o_present;
            tdone_reg    <= o_tdone;
            ldone_reg    <= f;
            err_reg      <= o_err;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_token_byte   = tok_byte_reg;
    assign m_byte_present = present_reg;
    assign m_token_done   = tdone_reg;
    assign m_line_done    = ldone_reg;
    assign m_error_code   = err_reg;

    a_err_only_on_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_line_done && !m_byte_present && !m_token_done)
        else $error("error code outside a line-end beat");

    a_final_resets_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_char |=> phase_reg == PH_BETWEEN && !failed_reg && fill_reg == '0)
        else $error("scan state not cleared after line end");

    a_fail_from_afterq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(failed_reg) |-> $past(phase_reg) == PH_AFTERQ && !$past(cfg.chunk_mode))
        else $error("line failure raised outside after-quote phase");

    a_chunk_byte_present: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cfg.chunk_mode && !failed_reg && s_ready |=> m_valid && m_byte_present)
        else $error("chunk mode character produced no byte");

endmodule

>>> verif/quote_aware_field_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// quote_aware_field_tokenizer_tb
// Self-checking bench for the quote-aware field tokenizer. A clocked driver
// sends characters from a queue and a clocked monitor predicts each beat from
// the accepted characters. The monitor then checks every result beat field by
// field. Phases step through merge, non-merge, chunk, quote-as-delimiter and
// saturated delimiter settings over the register port, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module quote_aware_field_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qaft_pkg::*;

    localparam int MAX_DELIM   = MAX_DELIM_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [BYTE_W-1:0] token_byte;
        logic              byte_present;
        logic              token_done;
        logic              line_done;
        err_t              error_code;
    } tok_beat_t;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              fin;
    } char_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_char_byte = '0;
    logic                 s_final_char = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_token_byte;
    logic                 m_byte_present;
    logic                 m_token_done;
    logic                 m_line_done;
    logic [ERR_W-1:0]     m_error_code;

    cfg_t                 tok_cfg;
    phase_t               scan_at = PH_BETWEEN;
    logic                 token_has_bytes = 1'b0;
    logic [BYTE_W-1:0]    chunk_fill = '0;
    logic                 line_failed = 1'b0;

    char_item_t           chars_to_send[$];
    char_item_t           next_char;
    tok_beat_t            token_beats_due[$];
    tok_beat_t            due_beat;
    tok_beat_t            want;
    logic [BYTE_W-1:0]    line_buf[$];
    logic                 s_took = 1'b0;
    logic                 idle_on = 1'b1;
    int                   send_gap = 0;
    int                   stall_left = 0;
    int                   mismatches = 0;
    int                   chars_queued = 0;
    int                   cycle_count = 0;

    quote_aware_field_tokenizer #(
        .MAX_DELIMITERS(MAX_DELIM)
    ) i_dut (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_char_byte, .s_final_char,
        .m_valid, .m_ready, .m_token_byte, .m_byte_present, .m_token_done,
        .m_line_done, .m_error_code
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int delim_total();
        int n;
        n = int'(tok_cfg.delimiter_count);
        if (n > DELIM_REGS) n = DELIM_REGS;
        if (n > MAX_DELIM) n = MAX_DELIM;
        return n;
    endfunction

    function automatic logic is_delim(input logic [BYTE_W-1:0] c);
        int i;
        for (i = 0; i < delim_total(); i++)
            if (tok_cfg.delim[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic tok_beat_t make_beat(input logic [BYTE_W-1:0] b, input logic present,
                                            input logic tdone, input logic ldone, input err_t e);
        tok_beat_t r;
        r.token_byte   = b;
        r.byte_present = present;
        r.token_done   = tdone;
        r.line_done    = ldone;
        r.error_code   = e;
        return r;
    endfunction

    function automatic logic scan_char(input logic [BYTE_W-1:0] c, input logic fin,
                                       output tok_beat_t r);
        logic              hit;
        logic              d;
        logic              tok;
        logic [BYTE_W-1:0] nxt;
        logic [BYTE_W-1:0] q;
        err_t              e;
        hit = 1'b1;
        r = make_beat('0, 1'b0, 1'b0, fin, ERR_NONE);
        if (line_failed) begin
            hit = fin;
            r.error_code = ERR_JUNK;
        end else if (tok_cfg.chunk_mode) begin
            nxt = chunk_fill + 8'd1;
            tok = (nxt == tok_cfg.chunk_length) || fin;
            chunk_fill = tok ? 8'd0 : nxt;
            r = make_beat(c, 1'b1, tok, fin, ERR_NONE);
        end else begin
            d = is_delim(c);
            case (scan_at)
                PH_PLAIN: begin
                    if (d) begin
                        scan_at = PH_BETWEEN;
                        r.token_done = 1'b1;
                    end else begin
                        r = make_beat(c, 1'b1, fin, fin, ERR_NONE);
                    end
                end
                PH_DQ, PH_SQ: begin
                    if (scan_at == PH_DQ) begin
                        q = CH_DQUOTE;
                        e = ERR_OPEN_DQ;
                    end else begin
                        q = CH_SQUOTE;
                        e = ERR_OPEN_SQ;
                    end
                    if (c == q) begin
                        scan_at = PH_AFTERQ;
                        hit = fin;
                        r.token_done = token_has_bytes || !tok_cfg.merge_mode;
                    end else if (fin) begin
                        r.error_code = e;
                    end else begin
                        token_has_bytes = 1'b1;
                        r = make_beat(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    end
                end
                PH_AFTERQ: begin
                    if (d) begin
                        tok = token_has_bytes || !tok_cfg.merge_mode;
                        token_has_bytes = 1'b0;
                        scan_at = PH_BETWEEN;
                        hit = tok || fin;
                        r.token_done = tok;
                    end else if (fin) begin
                        r.error_code = ERR_JUNK;
                    end else begin
                        line_failed = 1'b1;
                        hit = 1'b0;
                    end
                end
                default: begin
                    if (tok_cfg.merge_mode && d) begin
                        hit = fin;
                    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                        token_has_bytes = 1'b0;
                        hit = fin;
                        if (c == CH_DQUOTE) begin
                            scan_at = PH_DQ;
                            r.error_code = ERR_OPEN_DQ;
                        end else begin
                            scan_at = PH_SQ;
                            r.error_code = ERR_OPEN_SQ;
                        end
                    end else if (d) begin
                        r.token_done = 1'b1;
                    end else begin
                        scan_at = PH_PLAIN;
                        r = make_beat(c, 1'b1, fin, fin, ERR_NONE);
                    end
                end
            endcase
        end
        if (fin) begin
            scan_at = PH_BETWEEN;
            token_has_bytes = 1'b0;
            chunk_fill = '0;
            line_failed = 1'b0;
        end
        return hit;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("quote_aware_field_tokenizer: mismatch");
            $finish;
        end
    end

    // driver: advance only after the current beat is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (chars_to_send.size() != 0) begin
                next_char = chars_to_send.pop_front();
                s_valid <= 1'b1;
                s_char_byte <= next_char.ch;
                s_final_char <= next_char.fin;
                if (idle_on && $urandom_range(0, 7) == 0) send_gap <= int'($urandom_range(1, 11));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left <= int'($urandom_range(1, 11));
        end
    end

    // monitor: predict on accepted characters, check accepted result beats
    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (scan_char(s_char_byte, s_final_char, due_beat))
                    token_beats_due.insert(token_beats_due.size(), due_beat);
            end
            if (m_valid && m_ready) begin
                if (token_beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t unexpected beat: expected none, actual %0h %0b %0b %0b %0d",
                                 $time, m_token_byte, m_byte_present, m_token_done,
                                 m_line_done, m_error_code);
                end else begin
                    want = token_beats_due.pop_front();
                    check_field("token_byte", 32'(want.token_byte), 32'(m_token_byte));
                    check_field("byte_present", 32'(want.byte_present), 32'(m_byte_present));
                    check_field("token_done", 32'(want.token_done), 32'(m_token_done));
                    check_field("line_done", 32'(want.line_done), 32'(m_line_done));
                    check_field("error_code", 32'(want.error_code), 32'(m_error_code));
                end
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MERGE_MODE:  tok_cfg.merge_mode = val[0];
            REG_CHUNK_MODE:  tok_cfg.chunk_mode = val[0];
            REG_CHUNK_LEN:   tok_cfg.chunk_length = val[BYTE_W-1:0];
            REG_DELIM_COUNT: tok_cfg.delimiter_count = val[CNT_W-1:0];
            REG_DELIM_A:     tok_cfg.delim[0] = val[BYTE_W-1:0];
            REG_DELIM_B:     tok_cfg.delim[1] = val[BYTE_W-1:0];
            REG_DELIM_C:     tok_cfg.delim[2] = val[BYTE_W-1:0];
            REG_DELIM_D:     tok_cfg.delim[3] = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_char(input logic [BYTE_W-1:0] c, input logic fin);
        char_item_t it;
        it.ch = c;
        it.fin = fin;
        chars_to_send.insert(chars_to_send.size(), it);
        chars_queued++;
    endtask

    task automatic buf_char(input logic [BYTE_W-1:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endtask

    task automatic add_long_line(input int len);
        int i;
        for (i = 0; i < len; i++) push_char(BYTE_W'($urandom_range(0, 255)), i == len - 1);
    endtask

    function automatic logic [BYTE_W-1:0] delim_char();
        int n;
        n = delim_total();
        if (n == 0) return CH_SPACE;
        return tok_cfg.delim[$urandom_range(0, n - 1)];
    endfunction

    function automatic logic [BYTE_W-1:0] plain_char();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255));
        while (is_delim(c) || c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] any_but(input logic [BYTE_W-1:0] q);
        logic [BYTE_W-1:0] c;
        do begin
            if ($urandom_range(0, 3) == 0) c = delim_char();
            else c = BYTE_W'($urandom_range(0, 255));
        end while (c == q);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_char();
        case ($urandom_range(0, 5))
            0:       return CH_DQUOTE;
            1:       return CH_SQUOTE;
            2:       return delim_char();
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // style 0: well formed, 1: open or junk-followed quote at the tail, 2: noise
    task automatic add_line(input int style);
        int                ntok;
        int                k;
        int                len;
        int                i;
        int                kind;
        logic [BYTE_W-1:0] q;
        line_buf.delete();
        if (style == 2) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) buf_char(noise_char());
        end else begin
            ntok = $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) buf_char(delim_char());
            for (k = 0; k < ntok; k++) begin
                if (k > 0) begin
                    buf_char(delim_char());
                    if ($urandom_range(0, 2) == 0) buf_char(delim_char());
                end
                kind = $urandom_range(0, 3);
                if (kind < 2) begin
                    q = (kind == 0) ? CH_DQUOTE : CH_SQUOTE;
                    buf_char(q);
                    len = $urandom_range(0, 5);
                    for (i = 0; i < len; i++) buf_char(any_but(q));
                    buf_char(q);
                end else begin
                    len = $urandom_range(1, 6);
                    for (i = 0; i < len; i++) buf_char(plain_char());
                end
            end
            if ($urandom_range(0, 3) == 0) buf_char(delim_char());
            if (style == 1) begin
                buf_char(delim_char());
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                buf_char(q);
                len = $urandom_range(0, 3);
                for (i = 0; i < len; i++) buf_char(any_but(q));
                if ($urandom_range(0, 1)) begin
                    buf_char(q);
                    buf_char(plain_char());
                    len = $urandom_range(0, 3);
                    for (i = 0; i < len; i++) buf_char(noise_char());
                end
            end
        end
        for (i = 0; i < line_buf.size(); i++) push_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (chars_to_send.size() != 0 || s_valid || token_beats_due.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        int r;
        stop_at = chars_queued + n;
        while (chars_queued < stop_at) begin
            r = $urandom_range(0, 19);
            if (r < 14) add_line(0);
            else if (r < 17) add_line(1);
            else add_line(2);
        end
        // leave the line open across the next register update
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(1, 4);
            repeat (r) push_char(noise_char(), 1'b0);
        end
        wait_idle();
    endtask

    initial begin
        tok_cfg.merge_mode = 1'b1;
        tok_cfg.chunk_mode = 1'b0;
        tok_cfg.chunk_length = 8'd1;
        tok_cfg.delimiter_count = 3'd2;
        tok_cfg.delim[0] = CH_SPACE;
        tok_cfg.delim[1] = CH_TAB;
        tok_cfg.delim[2] = 8'd0;
        tok_cfg.delim[3] = 8'd0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_char(8'h00, 1'b0);
        push_char(8'hff, 1'b1);
        add_text(" ");
        add_text("\"x\" ");
        add_text("\"\"");
        add_text("'a");
        add_text("\"a\"bc");
        add_text("\"");
        add_text("a\t");
        wait_idle();
        chars_queued = 0;

        write_reg(REG_MERGE_MODE, 0);
        write_reg(REG_CHUNK_MODE, 0);
        write_reg(REG_CHUNK_LEN, 1);
        write_reg(REG_DELIM_COUNT, 4);
        write_reg(REG_DELIM_A, 32'h2c);
        write_reg(REG_DELIM_B, 32'h3b);
        write_reg(REG_DELIM_C, PDATA_W'(CH_DQUOTE));
        write_reg(REG_DELIM_D, 32'hff);
        run_phase(40);

        write_reg(REG_MERGE_MODE, 1);
        write_reg(REG_DELIM_COUNT, 3);
        run_phase(40);

        idle_on = 1'b0;
        write_reg(REG_CHUNK_MODE, 1);
        run_phase(40);

        idle_on = 1'b1;
        write_reg(REG_CHUNK_LEN, 255);
        add_long_line(258);
        run_phase(30);

        write_reg(REG_CHUNK_LEN, 0);
        add_long_line(260);
        run_phase(30);

        write_reg(REG_CHUNK_MODE, 0);
        write_reg(REG_MERGE_MODE, 0);
        write_reg(REG_DELIM_COUNT, 0);
        run_phase(40);

        write_reg(REG_MERGE_MODE, 1);
        write_reg(REG_DELIM_COUNT, 7);
        write_reg(REG_DELIM_A, 32'h00);
        write_reg(REG_DELIM_B, PDATA_W'(CH_SQUOTE));
        write_reg(REG_DELIM_C, PDATA_W'(CH_TAB));
        write_reg(REG_DELIM_D, PDATA_W'(CH_SPACE));
        run_phase(40);

        while (chars_queued < 860) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) write_reg(REG_MERGE_MODE, $urandom_range(0, 1));
            if ($urandom_range(0, 1))
                write_reg(REG_CHUNK_MODE, PDATA_W'($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 1))
                write_reg(REG_CHUNK_LEN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                      : $urandom_range(1, 8));
            if ($urandom_range(0, 1)) write_reg(REG_DELIM_COUNT, $urandom_range(0, 7));
            if ($urandom_range(0, 1)) write_reg(REG_DELIM_A, PDATA_W'(noise_char()));
            if ($urandom_range(0, 1)) write_reg(REG_DELIM_B, PDATA_W'(noise_char()));
            if ($urandom_range(0, 1)) write_reg(REG_DELIM_C, PDATA_W'(noise_char()));
            if ($urandom_range(0, 1)) write_reg(REG_DELIM_D, PDATA_W'(noise_char()));
            run_phase(60);
        end

        idle_on = 1'b0;
        write_reg(REG_MERGE_MODE, 1);
        write_reg(REG_CHUNK_MODE, 0);
        write_reg(REG_DELIM_COUNT, 2);
        write_reg(REG_DELIM_A, PDATA_W'(CH_SPACE));
        write_reg(REG_DELIM_B, PDATA_W'(CH_TAB));
        run_phase(40);

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("quote_aware_field_tokenizer: match");
        end else begin
            $display("quote_aware_field_tokenizer: mismatch");
        end
        $finish;
    end

endmodule
